[src/rn_pkg.sv]
// rn_pkg: shared types and constants for the rank_normalize block.
// No dependencies; used by every file under src.
package rn_pkg;

  localparam int MAX_VALUES = 64;
  localparam int VALUE_W    = 32;
  localparam int RANK_W     = 6;
  localparam int CNT_W      = $clog2(MAX_VALUES + 1);
  localparam int SETTLE_W   = $clog2(MAX_VALUES + 1);

  // Input word: one set element.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_word_t;

  // Output word: one rank of the run.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_res;
    logic              overflow;
  } out_word_t;

  // Token traveling down the cell row.
  typedef struct packed {
    logic                      vld;
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         cnt;
  } tok_t;

  // Row-wide control.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

[src/rn_cell.sv]
// rn_cell: one cell of the rank row; holds one value and its running rank.
// Depends on rn_pkg.
module rn_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  rn_pkg::cell_ctrl_t        ctrl,
  input  rn_pkg::tok_t              tok_in,
  output rn_pkg::tok_t              tok_out,
  input  logic [rn_pkg::RANK_W-1:0] shift_in,
  output logic [rn_pkg::RANK_W-1:0] rank
);

  logic                              full;
  logic signed [rn_pkg::VALUE_W-1:0] value;
  logic                              lt;
  logic                              gt;

  assign lt = value < tok_in.value;
  assign gt = tok_in.value < value;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      full        <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= 1'b0;
      if (ctrl.shift) begin
        rank <= shift_in;
      end else if (tok_in.vld) begin
        if (full) begin
          // pass the token on, counting this cell if it is smaller
          tok_out.vld   <= 1'b1;
          tok_out.value <= tok_in.value;
          tok_out.cnt   <= tok_in.cnt + rn_pkg::RANK_W'(lt);
          if (gt) begin
            rank <= rank + 1'b1;
          end
        end else begin
          // first empty cell takes the token
          full  <= 1'b1;
          value <= tok_in.value;
          rank  <= tok_in.cnt;
        end
      end
    end
  end

endmodule

[src/rn_row.sv]
// rn_row: the row of rn_cell instances, tokens flowing toward higher index,
// ranks shifting toward cell 0 for readout. Depends on rn_pkg, rn_cell.
module rn_row (
  input  logic                      clk,
  input  logic                      rst,
  input  rn_pkg::cell_ctrl_t        ctrl,
  input  rn_pkg::tok_t              tok_in,
  output logic [rn_pkg::RANK_W-1:0] head_rank
);

  rn_pkg::tok_t              tok  [rn_pkg::MAX_VALUES+1];
  logic [rn_pkg::RANK_W-1:0] rnk  [rn_pkg::MAX_VALUES+1];

  assign tok[0]                  = tok_in;
  assign rnk[rn_pkg::MAX_VALUES] = '0;
  assign head_rank               = rnk[0];

  for (genvar i = 0; i < rn_pkg::MAX_VALUES; i++) begin : g_cell
    rn_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1]),
      .shift_in (rnk[i+1]),
      .rank     (rnk[i])
    );
  end

endmodule

[src/rank_normalize.sv]
// rank_normalize: top level; sequencer around the rank cell row.
// Depends on rn_pkg, rn_row.
//
// Loads a set of signed 32-bit words, one per clock while busy is low, and
// after the word flagged last emits each element's rank (number of stored
// elements strictly smaller) in arrival order, one per clock on result with
// valid high for a single cycle; the receiver cannot stall. Loading runs at
// one word per cycle: each word enters a row of MAX_VALUES cells as a token
// that moves one cell per clock, counting smaller stored values and bumping
// the rank of larger ones, until it lands in the first empty cell. After the
// last word, busy stays high while the tokens land and then while the N ranks
// shift out of cell 0; busy drops in the cycle the final rank (last_res=1) is
// shown. Words past MAX_VALUES are dropped and overflow is set on every rank
// of that run. Equal values share a rank.
module rank_normalize (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rn_pkg::in_word_t item,
  output logic             valid,
  output rn_pkg::out_word_t result
);

  typedef enum logic [1:0] {LOAD, SETTLE, EMIT} state_t;

  state_t                      state;
  logic [rn_pkg::CNT_W-1:0]    count;      // elements stored
  logic [rn_pkg::CNT_W-1:0]    remaining;  // ranks left to emit
  logic [rn_pkg::SETTLE_W-1:0] settle;
  logic                        dropped;
  rn_pkg::tok_t                tok;        // token register feeding cell 0
  rn_pkg::cell_ctrl_t          ctrl;
  logic [rn_pkg::RANK_W-1:0]   head_rank;
  logic                        accept;

  assign busy   = (state != LOAD);
  assign accept = start && !busy;

  // Ranks shift out while emitting; the final shift clears the row instead.
  always_comb begin
    ctrl.shift = (state == EMIT);
    ctrl.clear = (state == EMIT) && (remaining == rn_pkg::CNT_W'(1));
  end

  rn_row u_row (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .tok_in    (tok),
    .head_rank (head_rank)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LOAD;
      count   <= '0;
      dropped <= 1'b0;
      settle  <= '0;
      remaining <= '0;
      tok.vld <= 1'b0;
      valid   <= 1'b0;
    end else begin
      tok.vld <= 1'b0;
      valid   <= 1'b0;
      case (state)
        LOAD: begin
          if (accept) begin
            if (count < rn_pkg::CNT_W'(rn_pkg::MAX_VALUES)) begin
              tok.vld   <= 1'b1;
              tok.value <= item.value;
              tok.cnt   <= '0;
              count     <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
            end
            if (item.last) begin
              state  <= SETTLE;
              settle <= '0;
            end
          end
        end
        SETTLE: begin
          // wait for the slowest token to reach its cell
          if (settle == rn_pkg::SETTLE_W'(rn_pkg::MAX_VALUES)) begin
            state     <= EMIT;
            remaining <= count;
          end else begin
            settle <= settle + 1'b1;
          end
        end
        EMIT: begin
          valid           <= 1'b1;
          result.rank     <= head_rank;
          result.last_res <= (remaining == rn_pkg::CNT_W'(1));
          result.overflow <= dropped;
          remaining       <= remaining - 1'b1;
          if (remaining == rn_pkg::CNT_W'(1)) begin
            state   <= LOAD;
            count   <= '0;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

endmodule

[src/rn_checker.sv]
// rn_checker: port-level assertions for rank_normalize, bound to the top.
// Depends on rn_pkg.
module rn_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input rn_pkg::in_word_t  item,
  input logic              valid,
  input rn_pkg::out_word_t result
);

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !result.last_res |-> busy)
    else $error("non-final rank shown while not busy");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.last |=> busy)
    else $error("last word did not start a run");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    valid && result.last_res |=> !valid)
    else $error("rank shown after final rank");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> valid && result.last_res)
    else $error("busy dropped without final rank");

  a_ovf_run: assert property (@(posedge clk) disable iff (rst)
    valid && !result.last_res |=> valid && (result.overflow == $past(result.overflow)))
    else $error("run broken or overflow changed within run");

endmodule

bind rank_normalize rn_checker u_rn_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .valid  (valid),
  .result (result)
);

[test/testbench.sv]
// testbench: self-checking bench for rank_normalize (start/busy word input, strobed ranks).
// Depends on rn_pkg and the rank_normalize RTL; a small class predicts and checks the ranks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rn_pkg::*;

  // Predicts the rank of each element of the set being loaded and checks the
  // rank words that come back. Equal values share a rank, words past capacity
  // are dropped but still flag overflow, and the last word closes the set.
  class rank_tracker;
    logic signed [VALUE_W-1:0] set_values [MAX_VALUES];
    logic [RANK_W-1:0]         set_ranks  [MAX_VALUES];
    int                        set_size;
    bit                        set_dropped;
    out_word_t                 expected_ranks [$];
    int                        errors;

    function new();
      set_size    = 0;
      set_dropped = 0;
      errors      = 0;
      foreach (set_ranks[i]) set_ranks[i] = '0;
    endfunction

    // Called for every word that the block accepts.
    function void note_word(in_word_t w);
      logic signed [VALUE_W-1:0] v;
      logic [RANK_W-1:0]         smaller;
      out_word_t                 r;
      v = w.value;
      if (set_size < MAX_VALUES) begin
        smaller = '0;
        for (int i = 0; i < set_size; i++) begin
          if (set_values[i] < v) smaller++;
          else if (v < set_values[i]) set_ranks[i] = set_ranks[i] + 1'b1;
        end
        set_values[set_size] = v;
        set_ranks[set_size]  = smaller;
        set_size++;
      end else begin
        set_dropped = 1'b1;
      end
      if (w.last) begin
        for (int i = 0; i < set_size; i++) begin
          r.rank     = set_ranks[i];
          r.last_res = (i == set_size - 1);
          r.overflow = set_dropped;
          expected_ranks.push_back(r);
        end
        foreach (set_ranks[i]) set_ranks[i] = '0;
        set_size    = 0;
        set_dropped = 0;
      end
    endfunction

    function void check_rank(out_word_t got);
      out_word_t exp_w;
      if (expected_ranks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: unexpected rank word %0d last %0b ovf %0b",
                   got.rank, got.last_res, got.overflow);
        return;
      end
      exp_w = expected_ranks.pop_front();
      if (got.rank !== exp_w.rank || got.last_res !== exp_w.last_res ||
          got.overflow !== exp_w.overflow) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected rank %0d last %0b ovf %0b, got rank %0d last %0b ovf %0b",
                   exp_w.rank, exp_w.last_res, exp_w.overflow,
                   got.rank, got.last_res, got.overflow);
      end
    endfunction

    function int pending();
      return expected_ranks.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  item;
  logic      valid;
  out_word_t result;

  rank_tracker board;
  int          words_sent;
  int          set_index;
  bit          idle_on;

  rank_normalize uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .valid  (valid),
    .result (result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Rank words are only up for one cycle; sampling at the falling edge reads
  // them mid-cycle, well clear of the edge that accepts them.
  always @(negedge clk) begin
    if (!rst && valid) board.check_rank(result);
  end

  // Offer one word and hold it until accepted. busy is sampled at the falling
  // edge so the acceptance decision never races the block's own update.
  // Entered and left at a rising edge.
  task automatic send_word(input logic signed [VALUE_W-1:0] v, input logic is_last);
    in_word_t w;
    int       gap;
    w.value = v;
    w.last  = is_last;
    item  <= w;
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    board.note_word(w);
    words_sent++;
    // Random idle: start drops for a few cycles. This lands during loading
    // and during the settle window after last alike.
    if (idle_on && $urandom_range(0, 99) < 9) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a whole set; the final entry carries last.
  task automatic send_set(input logic signed [VALUE_W-1:0] vals [$]);
    for (int i = 0; i < vals.size(); i++)
      send_word(vals[i], i == vals.size() - 1);
  endtask

  // Sender holds off until every predicted rank has come back.
  task automatic drain_ranks();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Value styles: full-range random, a narrow pool that forces duplicates,
  // and a mix leaning on the signed extremes and the zero crossing.
  function automatic logic signed [VALUE_W-1:0] pick_value(input int style);
    logic signed [VALUE_W-1:0] v;
    case (style)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          3: v = -1;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  // Set size: mostly short sets, some mid-sized, a few around and past capacity.
  function automatic int pick_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 10);
    if (roll < 92) return $urandom_range(11, 40);
    return $urandom_range(56, 70);
  endfunction

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic signed [VALUE_W-1:0] vals [$];
    int size;
    int style;
    int waited;

    board      = new();
    words_sent = 0;
    idle_on    = 1'b1;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: signed extremes, zero crossing, a duplicate pair.
    vals = '{32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 1, 5, 5, -5};
    send_set(vals);
    // Set of one element: last on the first word.
    vals = '{42};
    send_set(vals);
    // All equal: every rank is zero.
    vals = '{-1, -1, -1};
    send_set(vals);
    // Descending: every later word bumps all earlier cells.
    vals = '{3, 2, 1, 0};
    send_set(vals);

    // Random sets. The first two are pinned in size: exactly full, and
    // overfull so the closing word itself is dropped.
    set_index = 0;
    while (words_sent < 300) begin
      if (set_index == 0) size = MAX_VALUES;
      else if (set_index == 1) size = MAX_VALUES + 5;
      else size = pick_size();
      style = $urandom_range(0, 2);
      vals.delete();
      for (int i = 0; i < size; i++) vals.push_back(pick_value(style));
      // Long run without any sender idling.
      idle_on = !(set_index >= 8 && set_index < 18);
      send_set(vals);
      if (set_index == 4) drain_ranks();
      set_index++;
    end
    start <= 1'b0;

    waited = 0;
    while (board.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // Let any stray rank words surface: full settle window plus a margin.
    repeat (2 * MAX_VALUES + 8) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
